/* sv/rc_pkg.sv */
// Shared types, constants and helper functions for the radix converter.
package rc_pkg;

    localparam int CHAR_W    = 8;
    localparam int ST_W      = 2;
    localparam int BASE_W    = 5;
    localparam int DIG_W     = 4;
    localparam int DVAL_W    = 5;
    localparam int CFG_IDX_W = 1;
    localparam int Q_DEPTH   = 4;
    localparam int Q_AW      = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_SRC = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TGT = 1'd1;

    localparam logic [ST_W-1:0] ST_OK  = 2'd0;
    localparam logic [ST_W-1:0] ST_BAD = 2'd1;
    localparam logic [ST_W-1:0] ST_OVF = 2'd2;

    localparam logic [BASE_W-1:0] BASE_MIN   = 5'd2;
    localparam logic [BASE_W-1:0] BASE_MAX   = 5'd16;
    localparam logic [BASE_W-1:0] SRC_RESET  = 5'd5;
    localparam logic [BASE_W-1:0] TGT_RESET  = 5'd2;
    localparam logic [DVAL_W-1:0] DIGIT_NONE = 5'd16;

    localparam logic [CHAR_W-1:0] CH_0   = 8'h30;
    localparam logic [CHAR_W-1:0] CH_9   = 8'h39;
    localparam logic [CHAR_W-1:0] CH_UA  = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UF  = 8'h46;
    localparam logic [CHAR_W-1:0] CH_LA  = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LF  = 8'h66;
    localparam logic [CHAR_W-1:0] CH_TEN = 8'd10;
    localparam logic [CHAR_W-1:0] CH_NUL = 8'h00;

    localparam logic [CHAR_W-1:0] DIGIT_CHARS [16] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
    };

    typedef struct packed {
        logic [DVAL_W-1:0] dval;
        logic              last;
    } t_item;

    function automatic logic [BASE_W-1:0] clamp_base(input logic [BASE_W-1:0] b);
        logic [BASE_W-1:0] r;
        r = b;
        if (b < BASE_MIN) r = BASE_MIN;
        if (b > BASE_MAX) r = BASE_MAX;
        return r;
    endfunction

    function automatic logic [DVAL_W-1:0] char_value(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] t;
        t = CHAR_W'(0);
        if (c >= CH_0 && c <= CH_9) begin
            t = c - CH_0;
        end else if (c >= CH_UA && c <= CH_UF) begin
            t = c - CH_UA + CH_TEN;
        end else if (c >= CH_LA && c <= CH_LF) begin
            t = c - CH_LA + CH_TEN;
        end else begin
            t = CHAR_W'(DIGIT_NONE);
        end
        return t[DVAL_W-1:0];
    endfunction

    function automatic logic [CHAR_W-1:0] hex_char(input logic [DIG_W-1:0] d);
        return DIGIT_CHARS[d];
    endfunction

endpackage

/* sv/rc_in_if.sv */
// Input channel carrying one digit character word.
interface rc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] digit_char;
    logic       is_last;

    modport source (output valid, output digit_char, output is_last, input ready);
    modport sink   (input valid, input digit_char, input is_last, output ready);
endinterface

/* sv/rc_out_if.sv */
// Output channel carrying one converted digit or error word.
interface rc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       out_last;
    logic [1:0] status;

    modport source (output valid, output out_char, output out_last, output status,
                    input ready);
    modport sink   (input valid, input out_char, input out_last, input status,
                    output ready);
endinterface

/* sv/rc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module rc_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/rc_front.sv */
// Front end: accepts digit character words and classifies them into digit values.
module rc_front import rc_pkg::*; (
    rc_in_if.sink  i_in,
    input  logic   i_full,
    output logic   o_push,
    output t_item  o_item
);

    assign i_in.ready  = !i_full;
    assign o_push      = i_in.valid && !i_full;
    assign o_item.dval = char_value(i_in.digit_char);
    assign o_item.last = i_in.is_last;

endmodule

/* sv/rc_queue.sv */
// Short queue of classified digits between the front end and the converter.
module rc_queue import rc_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_valid,
    output t_item o_item
);

    t_item           r_entry [Q_DEPTH];
    logic [Q_AW-1:0] r_wptr;
    logic [Q_AW-1:0] r_rptr;
    logic [Q_AW:0]   r_count;
    logic            do_pop;

    assign o_valid = r_count != '0;
    assign o_full  = r_count == (Q_AW+1)'(Q_DEPTH);
    assign o_item  = r_entry[r_rptr];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + Q_AW'(1);
            end
            if (do_pop) begin
                r_rptr <= r_rptr + Q_AW'(1);
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + (Q_AW+1)'(1);
            end else if (!i_push && do_pop) begin
                r_count <= r_count - (Q_AW+1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wptr] <= i_item;
        end
    end

endmodule

/* sv/rc_back.sv */
// Back end: accumulates digit values, converts by repeated division and emits words.
module rc_back import rc_pkg::*; #(
    parameter int VALUE_BITS = 32,
    parameter int MAX_DIGITS = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [BASE_W-1:0] i_sb,
    input  logic [BASE_W-1:0] i_tb,
    input  logic              i_q_valid,
    input  t_item             i_q_item,
    output logic              o_q_pop,
    rc_out_if.source          o_out
);

    localparam int PROD_W = VALUE_BITS + BASE_W;
    localparam int SUM_W  = PROD_W + 1;
    localparam int CNT_W  = $clog2(MAX_DIGITS + 1);
    localparam int AW     = $clog2(MAX_DIGITS);
    localparam int BC_W   = $clog2(VALUE_BITS);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_EMIT = 3'd3;
    localparam logic [2:0] S_ERR  = 3'd4;

    logic [2:0]            r_state, n_state;
    logic [VALUE_BITS-1:0] r_acc, n_acc;
    logic [ST_W-1:0]       r_err, n_err;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic                  r_out_valid, n_out_valid;
    logic [VALUE_BITS-1:0] r_q, n_q;
    logic [DIG_W-1:0]      r_rem, n_rem;
    logic [BC_W-1:0]       r_bcnt, n_bcnt;
    logic [ST_W-1:0]       r_res_status, n_res_status;
    logic [CHAR_W-1:0]     r_out_char, n_out_char;
    logic                  r_out_last, n_out_last;
    logic [ST_W-1:0]       r_out_status, n_out_status;

    logic [PROD_W-1:0]     prod;
    logic [SUM_W-1:0]      sum;
    logic                  ovf;
    logic [VALUE_BITS-1:0] acc_item;
    logic [ST_W-1:0]       err_item;
    logic [BASE_W-1:0]     rs;
    logic                  ge;
    logic [DIG_W-1:0]      rem_n;
    logic [VALUE_BITS-1:0] q_n;
    logic [CNT_W-1:0]      cnt_inc;
    logic                  out_free;
    logic                  ram_we;
    logic [DIG_W-1:0]      ram_rdata;

    assign prod    = PROD_W'(r_acc) * PROD_W'(i_sb);
    assign sum     = SUM_W'(prod) + SUM_W'(i_q_item.dval);
    assign ovf     = |sum[SUM_W-1:VALUE_BITS];
    assign rs      = {r_rem, r_q[VALUE_BITS-1]};
    assign ge      = rs >= i_tb;
    assign rem_n   = ge ? DIG_W'(rs - i_tb) : rs[DIG_W-1:0];
    assign q_n     = {r_q[VALUE_BITS-2:0], ge};
    assign cnt_inc = r_cnt + CNT_W'(1);
    assign out_free = !r_out_valid || o_out.ready;
    assign o_q_pop = (r_state == S_IDLE) && i_q_valid;
    assign ram_we  = (r_state == S_DIV) && (r_bcnt == '0);

    always_comb begin
        acc_item = r_acc;
        err_item = r_err;
        if (r_err == ST_OK) begin
            if (i_q_item.dval >= i_sb) begin
                err_item = ST_BAD;
            end else if (ovf) begin
                err_item = ST_OVF;
            end else begin
                acc_item = sum[VALUE_BITS-1:0];
            end
        end
    end

    rc_ram #(
        .WIDTH (DIG_W),
        .DEPTH (MAX_DIGITS)
    ) u_digits (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_cnt[AW-1:0]),
        .i_wdata (rem_n),
        .i_raddr (AW'(r_cnt - CNT_W'(1))),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state      = r_state;
        n_acc        = r_acc;
        n_err        = r_err;
        n_cnt        = r_cnt;
        n_q          = r_q;
        n_rem        = r_rem;
        n_bcnt       = r_bcnt;
        n_res_status = r_res_status;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_out_char   = r_out_char;
        n_out_last   = r_out_last;
        n_out_status = r_out_status;
        case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    if (!i_q_item.last) begin
                        n_acc = acc_item;
                        n_err = err_item;
                    end else begin
                        n_acc = '0;
                        n_err = ST_OK;
                        if (err_item != ST_OK) begin
                            n_res_status = err_item;
                            n_state      = S_ERR;
                        end else begin
                            n_q     = acc_item;
                            n_rem   = '0;
                            n_bcnt  = BC_W'(VALUE_BITS - 1);
                            n_cnt   = '0;
                            n_state = S_DIV;
                        end
                    end
                end
            end
            S_DIV: begin
                n_q   = q_n;
                n_rem = rem_n;
                if (r_bcnt == '0) begin
                    n_cnt  = cnt_inc;
                    n_rem  = '0;
                    n_bcnt = BC_W'(VALUE_BITS - 1);
                    if (q_n == '0) begin
                        n_state = S_RD;
                    end else if (cnt_inc >= CNT_W'(MAX_DIGITS)) begin
                        n_res_status = ST_OVF;
                        n_state      = S_ERR;
                    end
                end else begin
                    n_bcnt = r_bcnt - BC_W'(1);
                end
            end
            S_RD: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_char   = hex_char(ram_rdata);
                    n_out_last   = r_cnt == CNT_W'(1);
                    n_out_status = ST_OK;
                    n_cnt        = r_cnt - CNT_W'(1);
                    n_state      = (r_cnt == CNT_W'(1)) ? S_IDLE : S_RD;
                end
            end
            S_ERR: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_char   = CH_NUL;
                    n_out_last   = 1'b1;
                    n_out_status = r_res_status;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_acc       <= '0;
            r_err       <= ST_OK;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_acc       <= n_acc;
            r_err       <= n_err;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q          <= n_q;
        r_rem        <= n_rem;
        r_bcnt       <= n_bcnt;
        r_res_status <= n_res_status;
        r_out_char   <= n_out_char;
        r_out_last   <= n_out_last;
        r_out_status <= n_out_status;
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.out_char = r_out_char;
    assign o_out.out_last = r_out_last;
    assign o_out.status   = r_out_status;

`ifndef SYNTH
    a_div_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_cnt < CNT_W'(MAX_DIGITS)))
        else $error("Digit count out of range during division.");

    a_div_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> ({1'b0, r_rem} < i_tb))
        else $error("Partial remainder not below the target base.");

    a_emit_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD || r_state == S_EMIT) |-> (r_cnt != '0))
        else $error("Emitting with no stored digits.");

    a_number_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ERR || r_state == S_DIV) |-> (r_acc == '0 && r_err == ST_OK))
        else $error("Accumulator not cleared after the final digit.");

    a_error_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status != ST_OK) |-> (r_out_last && r_out_char == CH_NUL))
        else $error("Error word is not a single final word.");
`endif

endmodule

/* sv/radix_converter_core.sv */
// Top level of the radix converter: configuration registers, front end, queue and back end.
//
//  Channel   Direction  Word
//  i_in      in         digit_char[7:0], is_last
//  o_out     out        out_char[7:0], out_last, status[1:0]
//  i_cfg_*   in         write of source base (index 0) or target base (index 1)
//
// A digit that is not the last is folded into the accumulator in the back end after queueing.
// A final digit is converted by the bit-serial divider, one output digit at a time,
// then each emitted word is read from the digit store in S_RD and sent in S_EMIT.
// Reset is synchronous and active low; bases return to 5 and 2.
// The four-word queue absorbs input while the divider or output is busy.
module radix_converter_core import rc_pkg::*; #(
    parameter int VALUE_BITS = 32,
    parameter int MAX_DIGITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [BASE_W-1:0]    i_cfg_wdata,
    rc_in_if.sink                i_in,
    rc_out_if.source             o_out
);

    logic [BASE_W-1:0] r_src_base;
    logic [BASE_W-1:0] r_tgt_base;
    logic              push;
    logic              full;
    t_item             push_item;
    logic              q_valid;
    logic              q_pop;
    t_item             q_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_base <= SRC_RESET;
            r_tgt_base <= TGT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SRC: r_src_base <= i_cfg_wdata;
                CFG_TGT: r_tgt_base <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    rc_front u_front (
        .i_in   (i_in),
        .i_full (full),
        .o_push (push),
        .o_item (push_item)
    );

    rc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    rc_back #(
        .VALUE_BITS (VALUE_BITS),
        .MAX_DIGITS (MAX_DIGITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_sb      (clamp_base(r_src_base)),
        .i_tb      (clamp_base(r_tgt_base)),
        .i_q_valid (q_valid),
        .i_q_item  (q_item),
        .o_q_pop   (q_pop),
        .o_out     (o_out)
    );

endmodule

/* dv/radix_conversion_check.sv */
// Checker for the radix converter: predicts every word and compares it on the output channel.
module radix_conversion_check import rc_pkg::*; #(
    parameter int VALUE_BITS = 32,
    parameter int MAX_DIGITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [BASE_W-1:0]    i_cfg_wdata,
    rc_in_if                     i_dig,
    rc_out_if                    i_res,
    output int                   o_mismatches,
    output int                   o_due,
    output int                   o_words_in,
    output int                   o_words_out,
    output int                   o_error_words
);

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
        logic [ST_W-1:0]   st;
    } t_conv_word;

    localparam longint unsigned VALUE_MAX =
        (VALUE_BITS >= 64) ? ~64'd0 : ((64'd1 << VALUE_BITS) - 64'd1);

    t_conv_word        digits_due [$];
    logic [BASE_W-1:0] src_base;
    logic [BASE_W-1:0] tgt_base;
    longint unsigned   value_acc;
    logic [ST_W-1:0]   error_seen;

    function automatic logic [BASE_W-1:0] effective_radix(input logic [BASE_W-1:0] b);
        return (b < BASE_MIN) ? BASE_MIN : ((b > BASE_MAX) ? BASE_MAX : b);
    endfunction

    function automatic logic [DVAL_W-1:0] ascii_digit_value(input logic [CHAR_W-1:0] c);
        if (c >= CH_0 && c <= CH_9) return DVAL_W'(c - CH_0);
        if (c >= CH_UA && c <= CH_UF) return DVAL_W'(c - CH_UA + CH_TEN);
        if (c >= CH_LA && c <= CH_LF) return DVAL_W'(c - CH_LA + CH_TEN);
        return DIGIT_NONE;
    endfunction

    function automatic logic [CHAR_W-1:0] digit_glyph(input logic [DIG_W-1:0] d);
        return (d < DIG_W'(10)) ? CH_0 + CHAR_W'(d) : CH_UA + CHAR_W'(d) - CH_TEN;
    endfunction

    task automatic fold_and_convert(input logic [CHAR_W-1:0] c, input logic last);
        logic [DVAL_W-1:0] d;
        logic [BASE_W-1:0] sb;
        logic [BASE_W-1:0] tb;
        longint unsigned   v;
        logic [DIG_W-1:0]  digs [MAX_DIGITS];
        int                n;
        bit                done;
        t_conv_word        w;
        sb = effective_radix(src_base);
        tb = effective_radix(tgt_base);
        d  = ascii_digit_value(c);
        if (error_seen == ST_OK) begin
            if (d >= sb) begin
                error_seen = ST_BAD;
            end else if (value_acc > (VALUE_MAX - d) / sb) begin
                error_seen = ST_OVF;
            end else begin
                value_acc = value_acc * sb + d;
            end
        end
        if (!last) return;
        n = 0;
        if (error_seen == ST_OK) begin
            v    = value_acc;
            done = 1'b0;
            while (!done) begin
                if (n >= MAX_DIGITS) begin
                    error_seen = ST_OVF;
                    done       = 1'b1;
                end else begin
                    digs[n] = DIG_W'(v % tb);
                    n++;
                    v    = v / tb;
                    done = (v == 0);
                end
            end
        end
        if (error_seen != ST_OK) begin
            w          = {CH_NUL, 1'b1, error_seen};
            digits_due = {digits_due, w};
            o_error_words++;
        end else begin
            for (int k = n - 1; k >= 0; k--) begin
                w          = {digit_glyph(digs[k]), k == 0, ST_OK};
                digits_due = {digits_due, w};
            end
        end
        value_acc  = 0;
        error_seen = ST_OK;
    endtask

    always @(posedge i_clk) begin : watch
        t_conv_word got;
        t_conv_word want;
        if (!i_rst_n) begin
            digits_due.delete();
            src_base      = SRC_RESET;
            tgt_base      = TGT_RESET;
            value_acc     = 0;
            error_seen    = ST_OK;
            o_mismatches  = 0;
            o_due         = 0;
            o_words_in    = 0;
            o_words_out   = 0;
            o_error_words = 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_SRC) begin
                    src_base = i_cfg_wdata;
                end else if (i_cfg_idx == CFG_TGT) begin
                    tgt_base = i_cfg_wdata;
                end
            end
            if (i_dig.valid && i_dig.ready) begin
                fold_and_convert(i_dig.digit_char, i_dig.is_last);
                o_words_in++;
            end
            if (i_res.valid && i_res.ready) begin
                got = {i_res.out_char, i_res.out_last, i_res.status};
                o_words_out++;
                if (digits_due.size() == 0) begin
                    if (o_mismatches < 10) begin
                        $display({"%0t: unexpected word char %h last %b status %0d",
                                  " with nothing due"},
                                 $time, got.ch, got.last, got.st);
                    end
                    o_mismatches++;
                end else begin
                    want = digits_due.pop_front();
                    if (got.ch !== want.ch || got.last !== want.last || got.st !== want.st) begin
                        if (o_mismatches < 10) begin
                            $display({"%0t: word %0d expected char %h last %b status %0d,",
                                      " got char %h last %b status %0d"},
                                     $time, o_words_out, want.ch, want.last, want.st,
                                     got.ch, got.last, got.st);
                        end
                        o_mismatches++;
                    end
                end
            end
            o_due = digits_due.size();
        end
    end

endmodule

/* dv/radix_converter_core_tb.sv */
// Testbench top for the radix converter: stimulus, base settings and the verdict.
module radix_converter_core_tb;
    import rc_pkg::*;

    localparam int HOLD_CYCLES  = 500;
    localparam int IDLE_LIMIT   = 20000;
    localparam int RANDOM_CHARS = 230;

    logic                 i_clk   = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [BASE_W-1:0]    i_cfg_wdata;

    rc_in_if  digit_ch ();
    rc_out_if result_ch ();

    int mismatches;
    int due;
    int words_in;
    int words_out;
    int error_words;

    int                chars_sent     = 0;
    int                numbers_sent   = 0;
    int                settings_used  = 0;
    int                idle_cycles    = 0;
    bit                hold_req       = 1'b0;
    bit                steady_phase   = 1'b0;
    logic [BASE_W-1:0] cur_src        = SRC_RESET;

    always #10 i_clk = ~i_clk;

    radix_converter_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (digit_ch),
        .o_out       (result_ch)
    );

    radix_conversion_check u_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_dig         (digit_ch),
        .i_res         (result_ch),
        .o_mismatches  (mismatches),
        .o_due         (due),
        .o_words_in    (words_in),
        .o_words_out   (words_out),
        .o_error_words (error_words)
    );

    function automatic int gap_len();
        int r;
        if (steady_phase) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic [BASE_W-1:0] pick_base();
        if ($urandom_range(0, 9) < 2) return BASE_W'($urandom_range(0, 31));
        return BASE_W'($urandom_range(2, 16));
    endfunction

    task automatic offer_char(input logic [CHAR_W-1:0] c, input logic last);
        int gap;
        gap = gap_len();
        if (gap > 0) begin
            digit_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        digit_ch.valid      <= 1'b1;
        digit_ch.digit_char <= c;
        digit_ch.is_last    <= last;
        do @(posedge i_clk); while (!digit_ch.ready);
        chars_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            offer_char(s[i], i == s.len() - 1);
        end
        numbers_sent++;
    endtask

    task automatic send_random_number();
        logic [BASE_W-1:0] sb;
        logic [CHAR_W-1:0] c;
        logic [DVAL_W-1:0] d;
        int                kind;
        int                len;
        int                bad_pos;
        sb      = (cur_src < BASE_MIN) ? BASE_MIN
                : ((cur_src > BASE_MAX) ? BASE_MAX : cur_src);
        kind    = $urandom_range(0, 99);
        len     = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 34) : $urandom_range(1, 10);
        bad_pos = (kind >= 80 && kind < 92) ? $urandom_range(0, len - 1) : -1;
        for (int i = 0; i < len; i++) begin
            if (kind >= 92 || i == bad_pos) begin
                c = CHAR_W'($urandom_range(0, 255));
            end else begin
                d = DVAL_W'($urandom_range(0, sb - 1));
                if (d < DVAL_W'(10)) begin
                    c = CH_0 + CHAR_W'(d);
                end else begin
                    c = ($urandom_range(0, 1) ? CH_UA : CH_LA) + CHAR_W'(d) - CH_TEN;
                end
            end
            offer_char(c, i == len - 1);
        end
        numbers_sent++;
    endtask

    task automatic drain();
        digit_ch.valid <= 1'b0;
        do @(negedge i_clk); while (due != 0);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic set_bases(input logic [BASE_W-1:0] src, input logic [BASE_W-1:0] tgt);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= CFG_SRC;
        i_cfg_wdata <= src;
        @(posedge i_clk);
        i_cfg_idx   <= CFG_TGT;
        i_cfg_wdata <= tgt;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cur_src = src;
        settings_used++;
    endtask

    initial begin
        int gap;
        result_ch.ready = 1'b0;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                result_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                gap = gap_len();
                if (gap > 0) begin
                    result_ch.ready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
                result_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (digit_ch.valid && digit_ch.ready)
                || (result_ch.valid && result_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Timed out after %0d cycles without a handshake", idle_cycles);
            $display("Mismatches found");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int start_chars;
        int phase;
        int phase_start;
        int phase_len;
        i_cfg_we            = 1'b0;
        i_cfg_idx           = CFG_SRC;
        i_cfg_wdata         = '0;
        digit_ch.valid      = 1'b0;
        digit_ch.digit_char = CH_NUL;
        digit_ch.is_last    = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset bases: plain value, zero, characters outside every digit range, digit equal to base.
        send_text("43");
        send_text("0");
        offer_char(8'h00, 1'b0);
        offer_char(8'hFF, 1'b1);
        numbers_sent++;
        send_text("15");
        // Out-of-range bases act as 16 and 2; the largest value gives the longest output.
        set_bases(5'd31, 5'd0);
        send_text("fFfFfFfF");
        // Overflow is kept as the error even though an invalid digit follows.
        set_bases(5'd16, 5'd31);
        send_text("100000000G");

        start_chars = chars_sent;
        phase       = 0;
        while (chars_sent - start_chars < RANDOM_CHARS) begin
            set_bases(pick_base(), pick_base());
            steady_phase = (phase % 4 == 3) || (phase == 2);
            if (phase == 2) hold_req = 1'b1;
            phase_start = chars_sent;
            phase_len   = $urandom_range(20, 35);
            while (chars_sent - phase_start < phase_len) send_random_number();
            phase++;
        end
        steady_phase = 1'b0;
        drain();

        $display({"Converted %0d numbers from %0d characters into %0d output words,",
                  " %0d of them errors."},
                 numbers_sent, words_in, words_out, error_words);
        $display({"Covered %0d base settings, out-of-range ones included,",
                  " and a %0d-cycle output stall."},
                 settings_used, HOLD_CYCLES);
        if (mismatches == 0 && due == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
